// ===== src/cflru_pkg.sv =====
// Shared widths, request codes and result type for the clean-first LRU controller.
`default_nettype none

package cflru_pkg;

    localparam int OP_W             = 2;
    localparam int PAGE_W           = 32;
    localparam int SLOT_W           = 4;
    localparam int WIN_W            = 5;
    localparam int S_TDATA_W        = 32;
    localparam int M_TDATA_W        = 40;
    localparam int M_TUSER_W        = 4;
    localparam int NUM_FRAMES_DEF   = 16;
    localparam int PAGE_ID_BITS_DEF = 32;

    localparam logic [WIN_W-1:0] WIN_RESET = 5'd4;

    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;
    localparam logic [OP_W-1:0] OP_RSVD  = 2'd3;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              fetch_needed;
        logic              evict_valid;
        logic              writeback_valid;
        logic [PAGE_W-1:0] victim_page;
        logic              last;
    } t_result;

endpackage

`default_nettype wire

// ===== src/cflru_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cflru_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/cflru_buffer_replacement.sv =====
// Clean-first LRU tag and replacement controller for a page buffer.
//
// Requests enter on the s-side stream: tuser carries the kind (read, write,
// flush), tdata the page number. Results leave on the m-side stream, one per
// read or write; on a flush one per dirty page, or one if none is; tlast marks
// the final one. The always-ready cfg channel writes the clean-search window.
//
// A read or write walks the tag RAM one frame per cycle; a miss on a full
// buffer adds a victim tag read (S_VRD). A flush steps once per recency rank
// up to the last dirty page, plus an output step (S_FOUT) per writeback. The
// tag RAM's registered read port shapes these steps. One request is in
// flight at a time; s_tready is high only while idle.
// Results sit in an output register: the next request is taken while one
// waits, and a stalled receiver holds the sequencer only when a new result
// is ready to go. Reset empties the buffer and sets the window to four.
`default_nettype none

module cflru_buffer_replacement #(
    parameter int NUM_FRAMES   = cflru_pkg::NUM_FRAMES_DEF,
    parameter int PAGE_ID_BITS = cflru_pkg::PAGE_ID_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration: window_size
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [cflru_pkg::WIN_W-1:0]     i_cfg_data,
    // requests
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [cflru_pkg::S_TDATA_W-1:0] i_s_tdata,  // page_id
    input  wire logic [cflru_pkg::OP_W-1:0]      i_s_tuser,  // op
    // results
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [cflru_pkg::M_TDATA_W-1:0]      o_m_tdata,  // slot, victim_page, zero pad
    output logic [cflru_pkg::M_TUSER_W-1:0]      o_m_tuser,  // hit, fetch_needed,
                                                             // evict_valid, writeback_valid
    output logic                                 o_m_tlast
);

    import cflru_pkg::*;

    localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CW = $clog2(NUM_FRAMES + 1);
    localparam int WW = (CW > WIN_W) ? CW : WIN_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOOK  = 3'd1;
    localparam logic [2:0] S_HIT   = 3'd2;
    localparam logic [2:0] S_FILL  = 3'd3;
    localparam logic [2:0] S_VRD   = 3'd4;
    localparam logic [2:0] S_VOUT  = 3'd5;
    localparam logic [2:0] S_FSCAN = 3'd6;
    localparam logic [2:0] S_FOUT  = 3'd7;

    logic [2:0]              r_state, n_state;
    logic [WIN_W-1:0]        r_window, n_window;
    logic [OP_W-1:0]         r_op, n_op;
    logic [PAGE_ID_BITS-1:0] r_pid, n_pid;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic [CW-1:0]           r_idx, n_idx;
    logic                    r_pend, n_pend;
    logic [FW-1:0]           r_pidx, n_pidx;
    logic                    r_cand_ok, n_cand_ok;
    logic [FW-1:0]           r_cand, n_cand;
    logic [FW-1:0]           r_cand_rank, n_cand_rank;
    logic [FW-1:0]           r_lru, n_lru;
    logic [FW-1:0]           r_sel, n_sel;
    logic [CW-1:0]           r_trank, n_trank;
    logic                    r_fl_any, n_fl_any;
    logic [NUM_FRAMES-1:0]   r_dirty, n_dirty;
    logic [FW-1:0]           r_rank [NUM_FRAMES];
    logic [FW-1:0]           n_rank [NUM_FRAMES];
    logic                    r_ovalid, n_ovalid;
    t_result                 r_out, n_out;

    logic                    w_out_free;
    logic                    w_emit;
    logic                    w_touch;
    logic [FW-1:0]           w_prank;
    logic [WW-1:0]           w_win;
    logic [WW-1:0]           w_thr;
    logic [NUM_FRAMES-1:0]   w_rmatch;
    logic [NUM_FRAMES-1:0]   w_fdirty;
    logic [NUM_FRAMES-1:0]   w_selmask;
    logic [FW-1:0]           w_ff;
    logic [FW-1:0]           w_raddr;
    logic                    w_we;
    logic [PAGE_ID_BITS-1:0] w_q;

    cflru_ram #(
        .WIDTH (PAGE_ID_BITS),
        .DEPTH (NUM_FRAMES)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_sel),
        .i_wdata (r_pid),
        .i_raddr (w_raddr),
        .o_rdata (w_q)
    );

    assign w_out_free = !r_ovalid || i_m_tready;
    assign w_prank    = r_rank[r_pidx];
    assign w_win      = (WW'(r_window) > WW'(NUM_FRAMES)) ? WW'(NUM_FRAMES) : WW'(r_window);
    assign w_thr      = WW'(NUM_FRAMES) - w_win;
    assign w_selmask  = NUM_FRAMES'(1) << r_sel;

    always_comb begin
        w_ff = '0;
        for (int g = 0; g < NUM_FRAMES; g++) begin
            w_rmatch[g] = (CW'(g) < r_cnt) && (CW'(r_rank[g]) == r_idx);
            if (w_rmatch[g]) begin
                w_ff = w_ff | FW'(g);
            end
        end
        w_fdirty = w_rmatch & r_dirty;
    end

    always_comb begin
        if (r_state == S_LOOK) begin
            w_raddr = r_idx[FW-1:0];
        end else if (r_state == S_FSCAN) begin
            w_raddr = w_ff;
        end else begin
            w_raddr = r_sel;
        end
    end

    assign w_emit = w_out_free && ((r_state == S_HIT) || (r_state == S_FILL) ||
                                   (r_state == S_VOUT) || (r_state == S_FOUT) ||
                                   ((r_state == S_FSCAN) && (r_dirty == '0) && !r_fl_any));
    assign w_touch = w_out_free && ((r_state == S_HIT) || (r_state == S_FILL) ||
                                    (r_state == S_VOUT));
    assign w_we = w_out_free && ((r_state == S_FILL) || (r_state == S_VOUT));

    always_comb begin
        n_state     = r_state;
        n_window    = r_window;
        n_op        = r_op;
        n_pid       = r_pid;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pidx      = r_pidx;
        n_cand_ok   = r_cand_ok;
        n_cand      = r_cand;
        n_cand_rank = r_cand_rank;
        n_lru       = r_lru;
        n_sel       = r_sel;
        n_trank     = r_trank;
        n_fl_any    = r_fl_any;
        n_dirty     = r_dirty;
        n_rank      = r_rank;
        n_ovalid    = r_ovalid;
        n_out       = r_out;

        if (i_cfg_valid) begin
            n_window = i_cfg_data;
        end

        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end

        if (w_touch) begin
            for (int g = 0; g < NUM_FRAMES; g++) begin
                if ((CW'(g) < r_cnt) && (FW'(g) != r_sel) && (CW'(r_rank[g]) < r_trank)) begin
                    n_rank[g] = r_rank[g] + FW'(1);
                end
            end
            n_rank[r_sel] = '0;
        end

        if (w_emit) begin
            n_ovalid = 1'b1;
            n_out    = '0;
            n_out.slot = SLOT_W'(r_sel);
            n_out.last = 1'b1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_op        = i_s_tuser;
                    n_pid       = PAGE_ID_BITS'(i_s_tdata);
                    n_idx       = '0;
                    n_pend      = 1'b0;
                    n_cand_ok   = 1'b0;
                    n_fl_any    = 1'b0;
                    unique case (i_s_tuser)
                        OP_READ, OP_WRITE: n_state = S_LOOK;
                        OP_FLUSH:          n_state = S_FSCAN;
                        OP_RSVD:           n_state = S_IDLE;
                    endcase
                end
            end
            S_LOOK: begin
                if (r_pend && (w_q == r_pid)) begin
                    n_sel   = r_pidx;
                    n_trank = CW'(w_prank);
                    n_state = S_HIT;
                end else if (!r_pend && (r_idx >= r_cnt)) begin
                    if (r_cnt < CW'(NUM_FRAMES)) begin
                        n_sel   = FW'(r_cnt);
                        n_trank = r_cnt;
                        n_state = S_FILL;
                    end else if (r_cand_ok) begin
                        n_sel   = r_cand;
                        n_trank = CW'(r_cand_rank);
                        n_state = S_VRD;
                    end else begin
                        n_sel   = r_lru;
                        n_trank = CW'(NUM_FRAMES - 1);
                        n_state = S_VRD;
                    end
                end else begin
                    if (r_pend) begin
                        if (!r_dirty[r_pidx] && (WW'(w_prank) >= w_thr) &&
                            (!r_cand_ok || (w_prank > r_cand_rank))) begin
                            n_cand_ok   = 1'b1;
                            n_cand      = r_pidx;
                            n_cand_rank = w_prank;
                        end
                        if (CW'(w_prank) == CW'(NUM_FRAMES - 1)) begin
                            n_lru = r_pidx;
                        end
                    end
                    n_pend = r_idx < r_cnt;
                    n_pidx = r_idx[FW-1:0];
                    if (r_idx < r_cnt) begin
                        n_idx = r_idx + CW'(1);
                    end
                end
            end
            S_HIT: begin
                if (w_out_free) begin
                    n_out.hit = 1'b1;
                    if (r_op == OP_WRITE) begin
                        n_dirty[r_sel] = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            S_FILL: begin
                if (w_out_free) begin
                    n_out.fetch_needed = (r_op == OP_READ);
                    n_dirty[r_sel]     = (r_op == OP_WRITE);
                    n_cnt              = r_cnt + CW'(1);
                    n_state            = S_IDLE;
                end
            end
            S_VRD: begin
                n_state = S_VOUT;
            end
            S_VOUT: begin
                if (w_out_free) begin
                    n_out.fetch_needed    = (r_op == OP_READ);
                    n_out.evict_valid     = 1'b1;
                    n_out.writeback_valid = r_dirty[r_sel];
                    n_out.victim_page     = PAGE_W'(w_q);
                    n_dirty[r_sel]        = (r_op == OP_WRITE);
                    n_state               = S_IDLE;
                end
            end
            S_FSCAN: begin
                if (r_dirty == '0) begin
                    if (r_fl_any) begin
                        n_state = S_IDLE;
                    end else if (w_out_free) begin
                        n_out.slot = '0;
                        n_state    = S_IDLE;
                    end
                end else if (|w_fdirty) begin
                    n_sel   = w_ff;
                    n_state = S_FOUT;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            S_FOUT: begin
                if (w_out_free) begin
                    n_out.writeback_valid = 1'b1;
                    n_out.victim_page     = PAGE_W'(w_q);
                    n_out.last            = ~|(r_dirty & ~w_selmask);
                    n_dirty[r_sel]        = 1'b0;
                    n_fl_any              = 1'b1;
                    n_idx                 = r_idx + CW'(1);
                    n_state               = S_FSCAN;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_window <= WIN_RESET;
            r_cnt    <= '0;
            r_dirty  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_window <= n_window;
            r_cnt    <= n_cnt;
            r_dirty  <= n_dirty;
            r_ovalid <= n_ovalid;
        end
        r_op        <= n_op;
        r_pid       <= n_pid;
        r_idx       <= n_idx;
        r_pend      <= n_pend;
        r_pidx      <= n_pidx;
        r_cand_ok   <= n_cand_ok;
        r_cand      <= n_cand;
        r_cand_rank <= n_cand_rank;
        r_lru       <= n_lru;
        r_sel       <= n_sel;
        r_trank     <= n_trank;
        r_fl_any    <= n_fl_any;
        r_rank      <= n_rank;
        r_out       <= n_out;
    end

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = {(M_TDATA_W - PAGE_W - SLOT_W)'(0), r_out.victim_page, r_out.slot};
    assign o_m_tuser   = {r_out.writeback_valid, r_out.evict_valid, r_out.fetch_needed,
                          r_out.hit};
    assign o_m_tlast   = r_out.last;

endmodule

`default_nettype wire

// ===== src/cflru_checker.sv =====
// Port-level checks for the clean-first LRU controller, bound to the top level.
`default_nettype none

module cflru_assertions (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_s_tvalid,
    input wire logic                            o_s_tready,
    input wire logic [cflru_pkg::OP_W-1:0]      i_s_tuser,
    input wire logic                            o_m_tvalid,
    input wire logic                            i_m_tready,
    input wire logic [cflru_pkg::M_TDATA_W-1:0] o_m_tdata,
    input wire logic [cflru_pkg::M_TUSER_W-1:0] o_m_tuser,
    input wire logic                            o_m_tlast
);

    import cflru_pkg::*;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tuser != OP_RSVD)) |=> !o_s_tready)
        else $error("request taken while previous request in progress");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
        (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast)))
        else $error("result changed while stalled");

    a_hit_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> ((o_m_tuser[3:1] == 3'b000) && o_m_tlast))
        else $error("hit result carries miss or flush flags");

    a_only_flush_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> (o_m_tuser[3] && !o_m_tuser[2] && !o_m_tuser[0]))
        else $error("non-final result that is not a flush writeback");

endmodule

bind cflru_buffer_replacement cflru_assertions u_cflru_assertions (.*);

`default_nettype wire
